@@ hdl/periodic_task_tick_scheduler_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Shared property forms for the port checker. Each macro expects signals
// named clk and rst to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTTS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ptts_pkg.sv @@
// ---------------------------------------------------------------------------
// Periodic task tick scheduler package
// Command and result word types, operation codes, mode and status codes.
// ---------------------------------------------------------------------------
package ptts_pkg;

  // Operation codes carried in the command word.
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DISPATCH   = 3'd1,
    OP_CREATE     = 3'd2,
    OP_SET_MODE   = 3'd3,
    OP_SET_PERIOD = 3'd4,
    OP_SET_COUNT  = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  // Task modes.
  localparam logic [1:0] MODE_PAUSED   = 2'd0;
  localparam logic [1:0] MODE_RUNNABLE = 2'd1;
  localparam logic [1:0] MODE_READY    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSLOT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Command word.
  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  task_id;
    logic [1:0]  mode_value;
    logic [15:0] time_value;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  slot_out;
    logic [1:0]  mode_out;
    logic [15:0] period_out;
    logic [15:0] count_out;
    logic [1:0]  status;
  } res_t;

  // Status from the update unit to the sequencer.
  typedef struct packed {
    logic wr;   // entry must be written back
    logic hit;  // entry was ready and has been dispatched
  } alu_flags_t;

endpackage

@@ hdl/ptts_table.sv @@
// ---------------------------------------------------------------------------
// Task table memory
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module ptts_table #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int EW    = 34
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ptts_alu.sv @@
// ---------------------------------------------------------------------------
// Task entry update unit
// Computes the new mode, counter and period of one task entry for the
// current operation, and tells the sequencer whether to write it back.
// ---------------------------------------------------------------------------
module ptts_alu
  import ptts_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  op_t                  op,
  input  logic [1:0]           mode_value,
  input  logic [TIME_BITS-1:0] time_value,
  input  logic [1:0]           mode_in,
  input  logic [TIME_BITS-1:0] count_in,
  input  logic [TIME_BITS-1:0] period_in,
  output logic [1:0]           mode_new,
  output logic [TIME_BITS-1:0] count_new,
  output logic [TIME_BITS-1:0] period_new,
  output alu_flags_t           flags
);

  localparam logic [TIME_BITS-1:0] ONE = TIME_BITS'(1);

  logic [1:0] mode_clean;

  // The unused mode code is taken as runnable.
  assign mode_clean = (mode_value == 2'd3) ? MODE_RUNNABLE : mode_value;

  // Entry update for each operation.
  always_comb begin
    mode_new   = mode_in;
    count_new  = count_in;
    period_new = period_in;
    flags      = '0;
    case (op)
      OP_TICK: begin
        if (mode_in != MODE_PAUSED) begin
          flags.wr = 1'b1;
          if (count_in >= period_in) begin
            count_new = ONE;
            mode_new  = MODE_READY;
          end else begin
            count_new = count_in + ONE;
          end
        end
      end
      OP_DISPATCH: begin
        flags.hit = (mode_in == MODE_READY);
        flags.wr  = flags.hit;
        mode_new  = MODE_RUNNABLE;
      end
      OP_CREATE: begin
        flags.wr   = 1'b1;
        mode_new   = mode_clean;
        count_new  = ONE;
        period_new = time_value;
      end
      OP_SET_MODE: begin
        flags.wr = 1'b1;
        mode_new = mode_clean;
        if (mode_clean == MODE_PAUSED) begin
          count_new = ONE;
        end
      end
      OP_SET_PERIOD: begin
        flags.wr   = 1'b1;
        period_new = time_value;
      end
      OP_SET_COUNT: begin
        flags.wr  = 1'b1;
        count_new = time_value;
      end
      default: begin
        flags = '0;
      end
    endcase
  end

endmodule

@@ hdl/periodic_task_tick_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// Periodic task tick scheduler core
// Table of periodic tasks with tick, dispatch, create, set and read commands.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Exactly one
// result word follows. It is shown for one cycle with result_valid and must
// be taken then, since the receiver cannot stall the block. The decode
// state gives the result for create, an unused command, every error case,
// and a tick or dispatch on an empty table. Set and read commands pass
// through the single-entry state after decode. A tick or dispatch on a
// table of created tasks visits every created task in the walk state; a
// dispatch that finds a ready slot stops there. The walk over the task
// table follows the ports: the table has one read port and one write port,
// so one task entry is read and one is updated per cycle through a single
// update unit. A new command may be accepted at the edge that ends the
// result cycle.
// ---------------------------------------------------------------------------
module periodic_task_tick_scheduler_core
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic result_valid,
  output res_t result
);

  localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > 3) ? CW : 3;
  localparam int EW   = 2 + 2 * TIME_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SINGLE
  } state_t;

  state_t               state;
  cmd_t                 cmd_q;
  logic [CW-1:0]        tasks_in_use;
  logic [CW-1:0]        rd_idx;
  logic                 pend;
  logic [AW-1:0]        pend_idx;

  op_t                  op_q;
  logic                 id_bad;
  logic                 table_full;
  logic [TIME_BITS-1:0] tv;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_wdata;
  logic [EW-1:0]        mem_rdata;

  logic [1:0]           upd_mode;
  logic [TIME_BITS-1:0] upd_count;
  logic [TIME_BITS-1:0] upd_period;
  alu_flags_t           flags;

  // Result word that carries only a status.
  function automatic res_t empty_word(logic [1:0] st);
    res_t w;
    w        = '0;
    w.status = st;
    return w;
  endfunction

  // Decoded fields of the held command.
  assign op_q       = op_t'(cmd_q.op);
  assign id_bad     = CMPW'(cmd_q.task_id) >= CMPW'(tasks_in_use);
  assign table_full = tasks_in_use >= CW'(MAX_TASKS);
  assign tv         = TIME_BITS'(cmd_q.time_value);

  // Task table.
  ptts_table #(
    .DEPTH (MAX_TASKS),
    .AW    (AW),
    .EW    (EW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared entry update unit.
  ptts_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op         (op_q),
    .mode_value (cmd_q.mode_value),
    .time_value (tv),
    .mode_in    (mem_rdata[EW-1 -: 2]),
    .count_in   (mem_rdata[2*TIME_BITS-1 -: TIME_BITS]),
    .period_in  (mem_rdata[TIME_BITS-1:0]),
    .mode_new   (upd_mode),
    .count_new  (upd_count),
    .period_new (upd_period),
    .flags      (flags)
  );

  // Table port control.
  always_comb begin
    mem_raddr = (state == S_DECODE) ? AW'(cmd_q.task_id) : AW'(rd_idx);
    mem_wdata = {upd_mode, upd_count, upd_period};
    mem_we    = 1'b0;
    mem_waddr = pend_idx;
    case (state)
      S_DECODE: begin
        mem_we    = (op_q == OP_CREATE) && !table_full;
        mem_waddr = AW'(tasks_in_use);
      end
      S_WALK: begin
        mem_we    = pend && flags.wr;
        mem_waddr = pend_idx;
      end
      S_SINGLE: begin
        mem_we    = flags.wr;
        mem_waddr = AW'(cmd_q.task_id);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer, task count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
      tasks_in_use <= '0;
      rd_idx       <= '0;
      pend         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            busy  <= 1'b1;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          rd_idx <= '0;
          pend   <= 1'b0;
          case (op_q)
            OP_TICK, OP_DISPATCH: begin
              if (tasks_in_use == '0) begin
                state        <= S_IDLE;
                busy         <= 1'b0;
                result_valid <= 1'b1;
                result       <= empty_word((op_q == OP_DISPATCH) ? ST_NONE : ST_OK);
              end else begin
                state <= S_WALK;
              end
            end
            OP_CREATE: begin
              state        <= S_IDLE;
              busy         <= 1'b0;
              result_valid <= 1'b1;
              if (table_full) begin
                result <= empty_word(ST_FULL);
              end else begin
                result.slot_out   <= 3'(tasks_in_use);
                result.mode_out   <= upd_mode;
                result.period_out <= 16'(upd_period);
                result.count_out  <= 16'(upd_count);
                result.status     <= ST_OK;
                tasks_in_use      <= CW'(tasks_in_use + 1'b1);
              end
            end
            OP_SET_MODE, OP_SET_PERIOD, OP_SET_COUNT, OP_READ: begin
              if (id_bad) begin
                state        <= S_IDLE;
                busy         <= 1'b0;
                result_valid <= 1'b1;
                result       <= empty_word(ST_NOSLOT);
              end else begin
                state <= S_SINGLE;
              end
            end
            default: begin
              state        <= S_IDLE;
              busy         <= 1'b0;
              result_valid <= 1'b1;
              result       <= empty_word(ST_OK);
            end
          endcase
        end

        // One entry read and one entry updated per cycle.
        S_WALK: begin
          if (pend && (op_q == OP_DISPATCH) && flags.hit) begin
            state             <= S_IDLE;
            busy              <= 1'b0;
            result_valid      <= 1'b1;
            result.slot_out   <= 3'(pend_idx);
            result.mode_out   <= upd_mode;
            result.period_out <= 16'(upd_period);
            result.count_out  <= 16'(upd_count);
            result.status     <= ST_OK;
          end else if (pend && (rd_idx == tasks_in_use)) begin
            state        <= S_IDLE;
            busy         <= 1'b0;
            result_valid <= 1'b1;
            result       <= empty_word((op_q == OP_DISPATCH) ? ST_NONE : ST_OK);
          end else begin
            pend     <= 1'b1;
            pend_idx <= AW'(rd_idx);
            rd_idx   <= CW'(rd_idx + 1'b1);
          end
        end

        // Entry of the addressed slot is in the read register now.
        S_SINGLE: begin
          state             <= S_IDLE;
          busy              <= 1'b0;
          result_valid      <= 1'b1;
          result.slot_out   <= cmd_q.task_id;
          result.mode_out   <= upd_mode;
          result.period_out <= 16'(upd_period);
          result.count_out  <= 16'(upd_count);
          result.status     <= ST_OK;
        end

        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/ptts_checker.sv @@
// ---------------------------------------------------------------------------
// Port checker for the periodic task tick scheduler
// Watches the command handshake and the result strobe over time.
// ---------------------------------------------------------------------------
`include "periodic_task_tick_scheduler_core_assert.svh"

module ptts_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // An accepted word keeps the block busy until its result.
  `PTTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

  // A result only appears once the block is free again.
  `PTTS_ASSERT_SAME(a_result_free, result_valid, !busy, "result shown while busy")

  // Every word gives one result, so strobes never come back to back.
  `PTTS_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid, "result strobe held twice")

  // The block only leaves busy by delivering a result.
  `PTTS_ASSERT_SAME(a_done_result, $past(busy) && !busy, result_valid, "busy dropped without result")

endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);

@@ tb/sv/periodic_task_tick_scheduler_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Periodic task tick scheduler core testbench
// Drives command words through the start/busy handshake and checks every
// result word against a cycle-free model of the task table kept here. A
// short directed list covers empty, full and bad-slot cases, pausing, odd
// mode values and period zero; a long random list follows on a full table.
// ---------------------------------------------------------------------------
module periodic_task_tick_scheduler_core_tb;
  import ptts_pkg::*;

  localparam int           NUM_SLOTS    = 8;
  localparam int           RAND_WORDS   = 900;
  localparam int           SETTLE_WAIT  = 24;
  localparam int           MAX_REPORTS  = 10;
  localparam logic [2:0]   OP_UNUSED    = 3'd7;
  localparam logic [1:0]   MODE_UNUSED  = 2'd3;

  // One command word waiting to go out, with its lead-in gap.
  typedef struct {
    cmd_t word;
    int   gap;
    bit   drain;
  } pending_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic result_valid;
  res_t result;

  pending_word_t pending_words[$];
  res_t          expected_results[$];

  // Model of the task table.
  logic [15:0] slot_period [NUM_SLOTS];
  logic [15:0] slot_count  [NUM_SLOTS];
  logic [1:0]  slot_mode   [NUM_SLOTS];
  int          used_slots = 0;

  // Run bookkeeping.
  int errors = 0;
  int words_out = 0;
  int words_back = 0;
  int checked = 0;
  int dispatch_hits = 0;
  int empty_dispatches = 0;
  int full_creates = 0;
  int bad_slots = 0;
  bit staged = 1'b0;

  periodic_task_tick_scheduler_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result word carrying one slot of the model table.
  function automatic res_t slot_word(int s);
    res_t r;
    r.slot_out   = s[2:0];
    r.mode_out   = slot_mode[s];
    r.period_out = slot_period[s];
    r.count_out  = slot_count[s];
    r.status     = ST_OK;
    return r;
  endfunction

  // Apply one command word to the model table and return its result word.
  function automatic res_t schedule_step(cmd_t c);
    res_t       r;
    logic [1:0] m;
    bit         found;
    int         i;
    r = '0;
    found = 1'b0;
    m = (c.mode_value == MODE_UNUSED) ? MODE_RUNNABLE : c.mode_value;
    case (c.op)
      OP_TICK: begin
        for (i = 0; i < used_slots; i++) begin
          if (slot_mode[i] != MODE_PAUSED) begin
            if (slot_count[i] >= slot_period[i]) begin
              slot_count[i] = 16'd1;
              slot_mode[i]  = MODE_READY;
            end else begin
              slot_count[i] = slot_count[i] + 16'd1;
            end
          end
        end
      end
      OP_DISPATCH: begin
        for (i = 0; i < used_slots && !found; i++) begin
          if (slot_mode[i] == MODE_READY) begin
            slot_mode[i] = MODE_RUNNABLE;
            r = slot_word(i);
            found = 1'b1;
          end
        end
        if (found) begin
          dispatch_hits++;
        end else begin
          r.status = ST_NONE;
          empty_dispatches++;
        end
      end
      OP_CREATE: begin
        if (used_slots >= NUM_SLOTS) begin
          r.status = ST_FULL;
          full_creates++;
        end else begin
          slot_period[used_slots] = c.time_value;
          slot_count[used_slots]  = 16'd1;
          slot_mode[used_slots]   = m;
          r = slot_word(used_slots);
          used_slots++;
        end
      end
      OP_SET_MODE, OP_SET_PERIOD, OP_SET_COUNT, OP_READ: begin
        if (int'(c.task_id) >= used_slots) begin
          r.status = ST_NOSLOT;
          bad_slots++;
        end else begin
          if (c.op == OP_SET_MODE) begin
            slot_mode[c.task_id] = m;
            // Pausing a task restarts its counter.
            if (m == MODE_PAUSED) slot_count[c.task_id] = 16'd1;
          end else if (c.op == OP_SET_PERIOD) begin
            slot_period[c.task_id] = c.time_value;
          end else if (c.op == OP_SET_COUNT) begin
            slot_count[c.task_id] = c.time_value;
          end
          r = slot_word(c.task_id);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cmd_t make_word(logic [2:0] op, logic [2:0] id, logic [1:0] mode,
                                     logic [15:0] tv);
    cmd_t c;
    c.op         = op;
    c.task_id    = id;
    c.mode_value = mode;
    c.time_value = tv;
    return c;
  endfunction

  // Mostly short times so that ticks reach the periods, sometimes any value.
  function automatic logic [15:0] pick_time();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 16'($urandom_range(12));
    if (sel < 9) return 16'($urandom_range(16'hFFFF));
    return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
  endfunction

  // Modes lean toward runnable and ready so that ticks keep tasks busy.
  function automatic logic [1:0] pick_mode();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return MODE_PAUSED;
    if (sel < 6) return MODE_RUNNABLE;
    if (sel < 9) return MODE_READY;
    return MODE_UNUSED;
  endfunction

  task automatic queue_word(cmd_t c, int gap, bit drain);
    pending_word_t p;
    p.word  = c;
    p.gap   = gap;
    p.drain = drain;
    pending_words.push_back(p);
  endtask

  // Driver: predicts each accepted word and presents the next one.
  always @(posedge clk) begin : driver
    logic          next_start;
    int            gap_left;
    pending_word_t stage;
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_results.push_back(schedule_step(cmd));
        words_out++;
        next_start = 1'b0;
      end
      if (result_valid) words_back++;
      if (!next_start) begin
        if (!staged && pending_words.size() > 0) begin
          stage = pending_words.pop_front();
          gap_left = stage.gap;
          staged = 1'b1;
        end
        if (staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!stage.drain || words_out == words_back) begin
            cmd <= stage.word;
            next_start = 1'b1;
            staged = 1'b0;
          end
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every result word must match the oldest expected word.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result word with nothing expected: slot %0d mode %0d status %0d",
                   result.slot_out, result.mode_out, result.status);
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (result.slot_out !== want.slot_out || result.mode_out !== want.mode_out ||
            result.period_out !== want.period_out || result.count_out !== want.count_out ||
            result.status !== want.status) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("ERROR: word %0d expected slot %0d mode %0d period %0h count %0h status %0d",
                     checked, want.slot_out, want.mode_out, want.period_out,
                     want.count_out, want.status);
            $display("       got slot %0d mode %0d period %0h count %0h status %0d",
                     result.slot_out, result.mode_out, result.period_out,
                     result.count_out, result.status);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int         k;
    int         sel;
    logic [2:0] op;
    bit         burst;

    // Directed words: empty table first.
    queue_word(make_word(OP_TICK, 3'd7, MODE_UNUSED, 16'hFFFF), 0, 1'b0);
    queue_word(make_word(OP_DISPATCH, 3'd0, MODE_PAUSED, 16'h0000), 0, 1'b0);
    queue_word(make_word(OP_READ, 3'd0, MODE_READY, 16'h1234), 3, 1'b0);
    // Period zero makes the task ready on every tick.
    queue_word(make_word(OP_CREATE, 3'd5, MODE_READY, 16'h0000), 0, 1'b0);
    queue_word(make_word(OP_SET_PERIOD, 3'd1, MODE_RUNNABLE, 16'h0040), 1, 1'b0);
    // Mode value three counts as runnable.
    queue_word(make_word(OP_CREATE, 3'd2, MODE_UNUSED, 16'hFFFF), 0, 1'b0);
    queue_word(make_word(OP_CREATE, 3'd7, MODE_PAUSED, 16'h0002), 2, 1'b0);
    queue_word(make_word(OP_TICK, 3'd0, MODE_PAUSED, 16'h0000), 0, 1'b1);
    queue_word(make_word(OP_DISPATCH, 3'd3, MODE_READY, 16'hAAAA), 0, 1'b0);
    queue_word(make_word(OP_DISPATCH, 3'd4, MODE_RUNNABLE, 16'h5555), 5, 1'b0);
    queue_word(make_word(OP_SET_COUNT, 3'd2, MODE_READY, 16'h0009), 0, 1'b0);
    queue_word(make_word(OP_SET_MODE, 3'd2, MODE_PAUSED, 16'hFFFF), 0, 1'b0);
    queue_word(make_word(OP_READ, 3'd2, MODE_PAUSED, 16'h0000), 0, 1'b0);
    queue_word(make_word(OP_SET_COUNT, 3'd1, MODE_PAUSED, 16'hFFFF), 6, 1'b0);
    queue_word(make_word(OP_TICK, 3'd6, MODE_READY, 16'h0001), 0, 1'b0);
    queue_word(make_word(OP_DISPATCH, 3'd0, MODE_PAUSED, 16'h0000), 0, 1'b0);
    queue_word(make_word(OP_DISPATCH, 3'd0, MODE_PAUSED, 16'h0000), 0, 1'b0);
    queue_word(make_word(OP_SET_MODE, 3'd0, MODE_UNUSED, 16'h0000), 4, 1'b0);
    queue_word(make_word(OP_UNUSED, 3'd7, MODE_UNUSED, 16'hFFFF), 0, 1'b0);
    // Fill the table, then one create too many.
    for (k = 0; k < 5; k++)
      queue_word(make_word(OP_CREATE, 3'($urandom_range(7)),
                           (k % 2 == 1) ? MODE_READY : MODE_RUNNABLE,
                           16'($urandom_range(6))), $urandom_range(2), 1'b0);
    queue_word(make_word(OP_CREATE, 3'd0, MODE_READY, 16'h0003), 0, 1'b0);
    queue_word(make_word(OP_READ, 3'd7, MODE_PAUSED, 16'h0000), 0, 1'b1);

    // Random words, with bursts of back-to-back traffic and a few full drains.
    for (k = 0; k < RAND_WORDS; k++) begin
      sel = $urandom_range(99);
      if (sel < 30)      op = OP_TICK;
      else if (sel < 50) op = OP_DISPATCH;
      else if (sel < 58) op = OP_SET_MODE;
      else if (sel < 66) op = OP_SET_PERIOD;
      else if (sel < 74) op = OP_SET_COUNT;
      else if (sel < 88) op = OP_READ;
      else if (sel < 94) op = OP_CREATE;
      else               op = OP_UNUSED;
      burst = ((k / 64) % 3 == 1);
      queue_word(make_word(op, 3'($urandom_range(7)), pick_mode(), pick_time()),
                 burst ? 0 : $urandom_range(6), (k % 200 == 199));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || staged || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("ERROR: %0d result words never arrived", expected_results.size());
    end

    $display("Checked %0d of %0d command words; %0d dispatches found a ready task, %0d none.",
             checked, words_out, dispatch_hits, empty_dispatches);
    $display("Refused creates on a full table: %0d; words naming an unused slot: %0d.",
             full_creates, bad_slots);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
